>>> rtl/xex_pkg.sv
// ----------------------------------------------------------------------------
// xex_pkg: shared types and constants for the x86 execute subset
// Operation codes, request and result layouts, memory write request.
// ----------------------------------------------------------------------------
package xex_pkg;

  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int BANK_AW   = MEM_AW - 1;
  localparam int NUM_REGS  = 12;
  localparam int REG_AW    = $clog2(NUM_REGS);

  localparam logic [REG_AW-1:0] CX_INDEX = REG_AW'(2);

  localparam logic [2:0] F_MOV     = 3'd0;
  localparam logic [2:0] F_ADD     = 3'd1;
  localparam logic [2:0] F_SUB     = 3'd2;
  localparam logic [2:0] F_CMP     = 3'd3;
  localparam logic [2:0] F_LOOP    = 3'd4;
  localparam logic [2:0] F_JNE     = 3'd5;
  localparam logic [2:0] F_OTHER   = 3'd6;
  localparam logic [2:0] F_PRELOAD = 3'd7;

  localparam logic [1:0] SRC_REG = 2'd0;
  localparam logic [1:0] SRC_IMM = 2'd1;

  typedef struct packed {
    logic [3:0]  ea_reg_second;
    logic [3:0]  ea_reg_first;
    logic [15:0] displacement;
    logic [15:0] imm_value;
    logic [4:0]  src_reg;
    logic [4:0]  dest_reg;
    logic        wide;
    logic [1:0]  src_kind;
    logic        dest_is_memory;
    logic [2:0]  inst_size;
    logic [2:0]  func;
  } item_t;

  typedef struct packed {
    logic              en;
    logic              wide;
    logic [MEM_AW-1:0] addr;
    logic [15:0]       data;
  } mem_wr_t;

  typedef struct packed {
    logic [15:0]       ip;
    logic              zf;
    logic              sf;
    logic [15:0]       result;
    logic              reg_we;
    logic [REG_AW-1:0] reg_idx;
    logic [15:0]       reg_data;
    mem_wr_t           mem_wr;
  } exec_out_t;

endpackage

>>> rtl/x86_16bit_execute_subset_top.sv
// ----------------------------------------------------------------------------
// x86_16bit_execute_subset_top: execute unit for decoded 16-bit x86 requests
// Register file, IP, flags and a byte memory; one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel, one decoded instruction per beat
//   (or a preload of one memory byte). Each produces exactly one result on
//   the m_axis channel: new IP, ZF, SF and the written or compared value.
//   Timing: when a request is taken, its effective address is formed from
//   the register file in that cycle and both memory banks are read at
//   that edge. The execute stage then writes memory, registers, IP and
//   flags and loads the output register once the output register is free,
//   and the result is shown from there. s_axis_tready stays low while a
//   request waits in the execute stage, which keeps a later read from
//   passing an earlier write to the byte banks, so a new request is not
//   taken until the previous one has executed.
//   Reset: rst clears registers, IP and flags, then a sweep zeroes both
//   memory banks one word a cycle, during which s_axis_tready stays low.
//   Stall: a held result stays in the output register; one more request
//   can be taken and then waits in the execute stage until the output frees.
// ----------------------------------------------------------------------------
module x86_16bit_execute_subset_top
  import xex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[2:0] inst_size[5:3] dest_is_memory[6] src_kind[8:7] wide[9]
  // dest_reg[14:10] src_reg[19:15] imm_value[35:20] displacement[51:36]
  // ea_reg_first[55:52] ea_reg_second[59:56], zero fill above
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_ip[15:0] zero_flag[16] sign_flag[17] result_value[33:18], zero fill
  output logic [39:0] m_axis_tdata
);

  logic [15:0] regs [NUM_REGS];
  logic [15:0] ip;
  logic        zf;
  logic        sf;

  item_t             in_item;
  item_t             b_item;
  logic              b_valid;
  logic [MEM_AW-1:0] b_ea;
  logic              accept;
  logic              done;
  logic              mem_ready;
  logic [15:0]       mem_data;
  logic [15:0]       ea_sum;
  logic [15:0]       term1;
  logic [15:0]       term2;
  logic [15:0]       src_word;
  logic [15:0]       dest_word;
  exec_out_t         res;
  mem_wr_t           mem_wr;

  function automatic logic [15:0] addr_term(input logic [3:0] code,
                                            input logic [15:0] r [NUM_REGS]);
    logic [3:0] idx;
    idx = code - 4'd1;
    if (code == 4'd0 || code > 4'(NUM_REGS)) begin
      return 16'd0;
    end
    return r[idx[REG_AW-1:0]];
  endfunction

  function automatic logic [15:0] reg_word(input logic [3:0] idx,
                                           input logic [15:0] r [NUM_REGS]);
    if (idx >= 4'(NUM_REGS)) begin
      return 16'd0;
    end
    return r[idx[REG_AW-1:0]];
  endfunction

  assign in_item       = s_axis_tdata[$bits(item_t)-1:0];
  assign s_axis_tready = !b_valid && mem_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign done          = b_valid && (!m_axis_tvalid || m_axis_tready);

  // Effective address from the registers as they stand at acceptance
  assign term1  = addr_term(in_item.ea_reg_first, regs);
  assign term2  = addr_term(in_item.ea_reg_second, regs);
  assign ea_sum = in_item.displacement + term1 + term2;

  assign src_word  = reg_word(b_item.src_reg[4:1], regs);
  assign dest_word = reg_word(b_item.dest_reg[4:1], regs);

  always_comb begin
    mem_wr    = res.mem_wr;
    mem_wr.en = res.mem_wr.en && done;
  end

  xex_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (ea_sum[MEM_AW-1:0]),
    .rd_data (mem_data),
    .wr      (mem_wr),
    .ready   (mem_ready)
  );

  xex_exec u_exec (
    .item      (b_item),
    .ea        (b_ea),
    .mem_data  (mem_data),
    .src_word  (src_word),
    .dest_word (dest_word),
    .cx_word   (regs[CX_INDEX]),
    .ip        (ip),
    .zf        (zf),
    .sf        (sf),
    .res       (res)
  );

  // Execute stage: hold the request until the output register can take it
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (done) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_item <= in_item;
      b_ea   <= ea_sum[MEM_AW-1:0];
    end
  end

  // Architectural state, advanced as each request completes
  always_ff @(posedge clk) begin
    if (rst) begin
      ip <= '0;
      zf <= 1'b0;
      sf <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else if (done) begin
      ip <= res.ip;
      zf <= res.zf;
      sf <= res.sf;
      if (res.reg_we) begin
        regs[res.reg_idx] <= res.reg_data;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (done) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_axis_tdata <= {6'd0, res.result, res.sf, res.zf, res.ip};
    end
  end

endmodule

>>> rtl/xex_mem.sv
// ----------------------------------------------------------------------------
// xex_mem: byte memory in even and odd banks
// Word read and write with address wrap; sweeps both banks to zero after reset.
// ----------------------------------------------------------------------------
module xex_mem
  import xex_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [MEM_AW-1:0] rd_addr,
  output logic [15:0]       rd_data,
  input  mem_wr_t           wr,
  output logic              ready
);

  logic [7:0] even_bank [MEM_BYTES/2];
  logic [7:0] odd_bank  [MEM_BYTES/2];

  logic               clearing;
  logic [BANK_AW-1:0] clr_idx;
  logic [7:0]         even_q;
  logic [7:0]         odd_q;
  logic               rd_odd;

  logic [MEM_AW-1:0]  rd_plus1;
  logic [MEM_AW-1:0]  wr_plus1;
  logic [BANK_AW-1:0] wr_even_idx;
  logic [BANK_AW-1:0] wr_odd_idx;
  logic [7:0]         wr_even_data;
  logic [7:0]         wr_odd_data;
  logic               wr_even_en;
  logic               wr_odd_en;

  assign ready    = !clearing;
  assign rd_plus1 = rd_addr + MEM_AW'(1);
  assign wr_plus1 = wr.addr + MEM_AW'(1);

  always_comb begin
    wr_even_idx  = wr_plus1[MEM_AW-1:1];
    wr_odd_idx   = wr.addr[MEM_AW-1:1];
    wr_even_en   = wr.en && (!wr.addr[0] || wr.wide);
    wr_odd_en    = wr.en && (wr.addr[0] || wr.wide);
    wr_even_data = wr.addr[0] ? wr.data[15:8] : wr.data[7:0];
    wr_odd_data  = wr.addr[0] ? wr.data[7:0] : wr.data[15:8];
    if (clearing) begin
      wr_even_idx  = clr_idx;
      wr_odd_idx   = clr_idx;
      wr_even_en   = 1'b1;
      wr_odd_en    = 1'b1;
      wr_even_data = 8'h00;
      wr_odd_data  = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + BANK_AW'(1);
      if (clr_idx == {BANK_AW{1'b1}}) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_even_en) begin
      even_bank[wr_even_idx] <= wr_even_data;
    end
    if (wr_odd_en) begin
      odd_bank[wr_odd_idx] <= wr_odd_data;
    end
    if (rd_en) begin
      even_q <= even_bank[rd_plus1[MEM_AW-1:1]];
      odd_q  <= odd_bank[rd_addr[MEM_AW-1:1]];
      rd_odd <= rd_addr[0];
    end
  end

  assign rd_data = rd_odd ? {even_q, odd_q} : {odd_q, even_q};

endmodule

>>> rtl/xex_exec.sv
// ----------------------------------------------------------------------------
// xex_exec: execute stage
// Operand select, add/sub, flags, branch target and write-back requests.
// ----------------------------------------------------------------------------
module xex_exec
  import xex_pkg::*;
(
  input  item_t             item,
  input  logic [MEM_AW-1:0] ea,
  input  logic [15:0]       mem_data,
  input  logic [15:0]       src_word,
  input  logic [15:0]       dest_word,
  input  logic [15:0]       cx_word,
  input  logic [15:0]       ip,
  input  logic              zf,
  input  logic              sf,
  output exec_out_t         res
);

  logic [15:0] mask;
  logic [15:0] mem_op;
  logic [15:0] src_op;
  logic [15:0] dst_op;
  logic [15:0] rv;
  logic [15:0] ip_adv;
  logic [15:0] cx_dec;
  logic [15:0] merged;

  function automatic logic [15:0] reg_operand(input logic [15:0] w, input logic hi,
                                              input logic wd);
    if (wd) begin
      return w;
    end
    return hi ? {8'h00, w[15:8]} : {8'h00, w[7:0]};
  endfunction

  always_comb begin
    mask   = item.wide ? 16'hFFFF : 16'h00FF;
    mem_op = mem_data & mask;
    ip_adv = ip + {13'd0, item.inst_size};
    cx_dec = cx_word - 16'd1;
    case (item.src_kind)
      SRC_REG: src_op = reg_operand(src_word, item.src_reg[0], item.wide);
      SRC_IMM: src_op = item.imm_value & mask;
      default: src_op = mem_op;
    endcase
    dst_op = item.dest_is_memory ? mem_op
                                 : reg_operand(dest_word, item.dest_reg[0], item.wide);
    case (item.func)
      F_MOV:   rv = src_op;
      F_ADD:   rv = (dst_op + src_op) & mask;
      default: rv = (dst_op - src_op) & mask;
    endcase
    if (item.wide) begin
      merged = rv;
    end else if (item.dest_reg[0]) begin
      merged = {rv[7:0], dest_word[7:0]};
    end else begin
      merged = {dest_word[15:8], rv[7:0]};
    end

    res             = '0;
    res.ip          = ip_adv;
    res.zf          = zf;
    res.sf          = sf;
    res.mem_wr.wide = item.wide;
    res.mem_wr.addr = ea;
    res.mem_wr.data = rv;
    res.reg_idx     = item.dest_reg[REG_AW:1];
    res.reg_data    = merged;
    case (item.func)
      F_MOV, F_ADD, F_SUB, F_CMP: begin
        res.result = rv;
        if (item.func != F_MOV) begin
          res.zf = (rv == 16'd0);
          res.sf = item.wide ? rv[15] : rv[7];
        end
        if (item.func != F_CMP) begin
          res.mem_wr.en = item.dest_is_memory;
          res.reg_we    = !item.dest_is_memory && (item.dest_reg[4:1] < 4'(NUM_REGS));
        end
      end
      F_LOOP: begin
        res.result   = cx_dec;
        res.reg_we   = 1'b1;
        res.reg_idx  = CX_INDEX;
        res.reg_data = cx_dec;
        if (cx_dec != 16'd0) begin
          res.ip = ip_adv + item.imm_value;
        end
      end
      F_JNE: begin
        if (!zf) begin
          res.ip = ip_adv + item.imm_value;
        end
      end
      F_PRELOAD: begin
        res.ip          = ip;
        res.result      = {8'h00, item.imm_value[7:0]};
        res.mem_wr.en   = 1'b1;
        res.mem_wr.wide = 1'b0;
        res.mem_wr.addr = item.displacement[MEM_AW-1:0];
        res.mem_wr.data = {8'h00, item.imm_value[7:0]};
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/xex_chk.sv
// ----------------------------------------------------------------------------
// xex_chk: port checker for the execute unit
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module xex_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // No request is taken in the cycle after one is accepted
  a_interlock: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken during execute cycle");

  // A request taken while the output is free yields a result from the output register after the execute stage
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready)
      |=> ##1 m_axis_tvalid)
    else $error("missing result");

endmodule

bind x86_16bit_execute_subset_top xex_chk u_xex_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/xex_checker.sv
// ----------------------------------------------------------------------------
// xex_checker: result checker for the x86 execute subset
// Watches both stream channels, predicts each result from an accepted request
// using its own copy of registers, IP, flags and memory, and compares.
// ----------------------------------------------------------------------------
module xex_checker
  import xex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Same layout as the result bus, lowest field last
  typedef struct packed {
    logic [15:0] value;
    logic        sf;
    logic        zf;
    logic [15:0] ip;
  } cpu_result_t;

  logic [15:0] regs [NUM_REGS];
  logic [7:0]  mem [MEM_BYTES];
  logic [15:0] ip;
  logic        zf, sf;
  cpu_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [15:0] reg_rd(logic [4:0] idx);
    return (idx < NUM_REGS) ? regs[idx] : 16'h0;
  endfunction

  function automatic logic [15:0] mem_rd(logic [15:0] a, logic w);
    logic [15:0] hi;
    hi = w ? {mem[16'(a + 16'd1) % MEM_BYTES], 8'h0} : 16'h0;
    return hi | mem[a % MEM_BYTES];
  endfunction

  function automatic logic [15:0] ea_term(logic [3:0] code);
    return (code == 0 || code > NUM_REGS) ? 16'h0 : regs[code - 1];
  endfunction

  function automatic logic [15:0] opnd_rd(logic [4:0] sel, logic w);
    logic [15:0] v;
    v = reg_rd(sel >> 1);
    if (w) return v;
    return sel[0] ? {8'h0, v[15:8]} : {8'h0, v[7:0]};
  endfunction

  // Execute one request against the shadow state.
  function automatic cpu_result_t execute_instr(item_t it);
    cpu_result_t res;
    logic [15:0] mask, ea, s, d, r, old, cx;
    logic [4:0]  idx;
    r = 16'h0;
    if (it.func == F_PRELOAD) begin
      mem[it.displacement % MEM_BYTES] = it.imm_value[7:0];
      r = {8'h0, it.imm_value[7:0]};
    end else begin
      ip = ip + 16'(it.inst_size);
      if (it.func <= F_CMP) begin
        mask = it.wide ? 16'hFFFF : 16'h00FF;
        ea = it.displacement + ea_term(it.ea_reg_first) + ea_term(it.ea_reg_second);
        if (it.src_kind == SRC_REG) s = opnd_rd(it.src_reg, it.wide);
        else if (it.src_kind == SRC_IMM) s = it.imm_value & mask;
        else s = mem_rd(ea, it.wide);
        d = it.dest_is_memory ? mem_rd(ea, it.wide) : opnd_rd(it.dest_reg, it.wide);
        if (it.func == F_MOV) r = s;
        else if (it.func == F_ADD) r = (d + s) & mask;
        else r = (d - s) & mask;
        if (it.func != F_MOV) begin
          zf = (r == 0);
          sf = it.wide ? r[15] : r[7];
        end
        if (it.func != F_CMP) begin
          if (it.dest_is_memory) begin
            mem[ea % MEM_BYTES] = r[7:0];
            if (it.wide) mem[16'(ea + 16'd1) % MEM_BYTES] = r[15:8];
          end else begin
            idx = it.dest_reg >> 1;
            old = reg_rd(idx);
            if (idx < NUM_REGS) begin
              if (it.wide) regs[idx] = r;
              else if (it.dest_reg[0]) regs[idx] = {r[7:0], old[7:0]};
              else regs[idx] = {old[15:8], r[7:0]};
            end
          end
        end
      end else if (it.func == F_LOOP) begin
        cx = regs[CX_INDEX] - 16'd1;
        regs[CX_INDEX] = cx;
        if (cx != 0) ip = ip + it.imm_value;
        r = cx;
      end else if (it.func == F_JNE) begin
        if (!zf) ip = ip + it.imm_value;
      end
    end
    res.ip = ip;
    res.zf = zf;
    res.sf = sf;
    res.value = r;
    return res;
  endfunction

  always @(posedge clk) begin
    cpu_result_t exp_r, act;
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
      for (int i = 0; i < MEM_BYTES; i++) mem[i] = '0;
      ip = '0;
      zf = 1'b0;
      sf = 1'b0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        act = m_axis_tdata[33:0];
        if (expected_results.size() == 0) begin
          $error("unexpected result %h", act);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (act.ip != exp_r.ip) begin
            $error("next_ip exp %h got %h", exp_r.ip, act.ip); fail_count++;
          end
          if (act.zf != exp_r.zf) begin
            $error("zero_flag exp %b got %b", exp_r.zf, act.zf); fail_count++;
          end
          if (act.sf != exp_r.sf) begin
            $error("sign_flag exp %b got %b", exp_r.sf, act.sf); fail_count++;
          end
          if (act.value != exp_r.value) begin
            $error("result_value exp %h got %h", exp_r.value, act.value); fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(execute_instr(item_t'(s_axis_tdata[59:0])));
    end
  end
endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the x86 execute subset
// Drives directed and random decoded requests with random gaps and output
// stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import xex_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  // Memory source kinds; the upper one also reads memory
  localparam logic [1:0] SRC_MEM     = 2'd2;
  localparam logic [1:0] SRC_MEM_ALT = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;

  // Toggle every half period.
  always #5 clk = ~clk;

  x86_16bit_execute_subset_top dut (.*);

  xex_checker u_checker (.*);

  // Bound the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("x86_16bit_execute_subset_top: mismatch");
      $finish;
    end
  end

  // Output stall: mostly short, sometimes long, with stall-free stretches.
  logic stall_free = 1'b0;
  int   hold_left = 0;
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!stall_free && $urandom_range(0, 3) == 0) begin
      hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
    if ($urandom_range(0, 199) == 0) stall_free <= ~stall_free;
  end

  // Send one request at the next falling edge; hold until accepted, then drop.
  task automatic send_request(item_t it);
    @(negedge clk);
    s_axis_tdata  <= {4'h0, it};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    repeat (n) @(negedge clk);
  endtask

  function automatic item_t make_op(logic [2:0] f, logic w, logic dm, logic [1:0] sk,
                                    logic [4:0] dr, logic [4:0] sr, logic [15:0] imm,
                                    logic [15:0] disp, logic [3:0] e1, logic [3:0] e2);
    item_t it;
    it.func = f;
    it.inst_size = 3'($urandom_range(0, 6));
    it.wide = w;
    it.dest_is_memory = dm;
    it.src_kind = sk;
    it.dest_reg = dr;
    it.src_reg = sr;
    it.imm_value = imm;
    it.displacement = disp;
    it.ea_reg_first = e1;
    it.ea_reg_second = e2;
    return it;
  endfunction

  // Random instruction, biased toward small addresses so memory is reused.
  function automatic item_t random_op();
    item_t it;
    it = item_t'({$urandom, $urandom});
    it.func = 3'($urandom_range(0, 7));
    it.inst_size = 3'($urandom_range(0, 6));
    if ($urandom_range(0, 3) != 0) begin
      it.dest_reg = 5'($urandom_range(0, 23));
      it.src_reg  = 5'($urandom_range(0, 23));
      it.src_kind = 2'($urandom_range(0, 2));
      it.ea_reg_first  = 4'($urandom_range(0, 12));
      it.ea_reg_second = ($urandom_range(0, 1)) ? 4'd0 : 4'($urandom_range(0, 12));
      if ($urandom_range(0, 3) != 0) it.displacement = 16'($urandom_range(0, 63));
    end
    return it;
  endfunction

  initial begin
    item_t it;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: preload, every operation, extremes and special cases.
    send_request(make_op(F_PRELOAD, 0, 0, 0, 0, 0, 16'h12FF, 16'hFFFF, 0, 0));
    send_request(make_op(F_PRELOAD, 0, 0, 0, 0, 0, 16'h0080, 16'h0000, 0, 0));
    send_request(make_op(F_MOV, 1, 0, SRC_IMM, 5'd4, 0, 16'hFFFF, 0, 0, 0));    // CX
    send_request(make_op(F_MOV, 1, 0, SRC_MEM, 5'd0, 0, 0, 16'hFFFF, 0, 0));    // wrap word
    send_request(make_op(F_ADD, 0, 0, SRC_IMM, 5'd1, 0, 16'h0001, 0, 0, 0));    // AH
    send_request(make_op(F_SUB, 1, 0, SRC_REG, 5'd2, 5'd2, 0, 0, 0, 0));        // zero
    send_request(make_op(F_CMP, 0, 0, SRC_IMM, 5'd0, 0, 16'h0001, 0, 0, 0));
    send_request(make_op(F_ADD, 1, 1, SRC_MEM, 0, 0, 0, 16'h0000, 4'd1, 4'd3)); // mem-mem
    send_request(make_op(F_MOV, 1, 0, SRC_REG, 5'd31, 5'd30, 0, 0, 0, 0));      // bad regs
    send_request(make_op(F_MOV, 0, 1, SRC_MEM_ALT, 0, 0, 0, 16'h0010, 4'd15, 4'd13));
    send_request(make_op(F_SUB, 1, 1, SRC_IMM, 0, 0, 16'h8000, 16'hFFFF, 4'd12, 0));
    send_request(make_op(F_LOOP, 0, 0, 0, 0, 0, 16'hFFF0, 0, 0, 0));
    send_request(make_op(F_JNE, 0, 0, 0, 0, 0, 16'h7FFF, 0, 0, 0));
    send_request(make_op(F_OTHER, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0));
    send_request(make_op(F_MOV, 1, 0, SRC_IMM, 5'd4, 0, 16'h0001, 0, 0, 0));
    send_request(make_op(F_LOOP, 0, 0, 0, 0, 0, 16'h1234, 0, 0, 0));            // CX -> 0
    send_request(make_op(F_CMP, 1, 0, SRC_REG, 5'd0, 5'd0, 0, 0, 0, 0));
    send_request(make_op(F_JNE, 0, 0, 0, 0, 0, 16'h0100, 0, 0, 0));             // not taken

    // Pause until every outstanding result has drained.
    while (pending != 0) @(negedge clk);

    for (int i = 0; i < 1400; i++) begin
      it = random_op();
      send_request(it);
      idle_gap();
      if (i == 700) while (pending != 0) @(negedge clk);
    end

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("x86_16bit_execute_subset_top: match");
    else
      $display("x86_16bit_execute_subset_top: mismatch");
    $finish;
  end
endmodule

>>> x86_16bit_execute_subset_top.f
rtl/xex_pkg.sv
rtl/xex_mem.sv
rtl/xex_exec.sv
rtl/x86_16bit_execute_subset_top.sv
rtl/xex_chk.sv
tb/sv/xex_checker.sv
tb/sv/tb_top.sv
